// ===== design/mmn_pkg.sv =====
// ----------------------------------------------------------------------------
// mmn_pkg: shared types and constants of the min-max feature normalizer
// Widths, item codes, result status codes and the work descriptor that the
// front end hands to the back end.
// ----------------------------------------------------------------------------
package mmn_pkg;

  localparam int SlotCount  = 64;
  localparam int IdxW       = 6;
  localparam int SampleW    = 32;
  localparam int FracW      = 16;
  localparam int ScaledW    = FracW + 1;
  localparam int CfgW       = 7;
  localparam int RemW       = SampleW + 1;
  localparam int CntW       = $clog2(ScaledW);
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);
  localparam int RowW       = 2 * SampleW;

  localparam logic [ScaledW-1:0] ScaledOne = ScaledW'(1) << FracW;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_FIT   = 2'd1,
    MODE_APPLY = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_CLAMP_LOW  = 3'd1,
    ST_CLAMP_HIGH = 3'd2,
    ST_FLAT       = 3'd3,
    ST_BAD_IDX    = 3'd4
  } status_e;

  typedef enum logic {
    OP_FIT   = 1'b0,
    OP_APPLY = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOOK,
    BK_DIV,
    BK_EMIT
  } back_state_e;

  // One unit of work for the back end
  typedef struct packed {
    op_e                 op;
    logic                first;      // fit: column was unfitted, load both bounds
    logic                preset;     // apply: status already decided up front
    status_e             pre_status;
    logic [IdxW-1:0]     idx;
    logic [SampleW-1:0]  sample;
  } work_t;

endpackage

// ===== design/min_max_feature_normalizer.sv =====
// ----------------------------------------------------------------------------
// min_max_feature_normalizer: per-column min-max scaling
// Fits per-column minimum and maximum from samples and maps apply samples
// to (sample - min) / (max - min) in unsigned Q1.16, clamped to [0, 1].
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i/in_ready_o   mode_i, feature_index_i, sample_i
//   out      output     out_valid_o/out_ready_i scaled_o, status_o
//   cfg      input      cfg_we_i                cfg_wdata_i (features_in_use)
//
// Clear items are handled in the front end alone. Fit items are popped from
// the queue with a bounds read, then written back. Apply items go through pop,
// bounds check, 17 restoring divider steps of one quotient bit each, hand-off;
// clamped, flat and bad-index applies skip the divider. A two-entry
// queue lets the front end keep taking items while the back end works. Reset
// clears the flags and sets 64 columns; a stalled output backs up queue, input.
// ----------------------------------------------------------------------------
module min_max_feature_normalizer import mmn_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          mode_i,
  input  logic [IdxW-1:0]     feature_index_i,
  input  logic [SampleW-1:0]  sample_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [ScaledW-1:0]  scaled_o,
  output logic [2:0]          status_o
);

  logic  q_push, q_pop, q_full, q_empty;
  work_t q_wdata, q_rdata;

  // Intake and classification
  mmn_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .feature_index_i (feature_index_i),
    .sample_i        (sample_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_data_o        (q_wdata)
  );

  // Work queue
  mmn_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Bounds table and divider
  mmn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_data_i    (q_rdata),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .scaled_o    (scaled_o),
    .status_o    (status_o)
  );

  // Clamped high always reports exactly one
  a_high_is_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_CLAMP_HIGH |-> scaled_o == ScaledOne)
    else $error("clamped high result is not one");

  // Low, flat and bad-index results report zero
  a_zero_cases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_CLAMP_LOW || status_o == ST_FLAT ||
                    status_o == ST_BAD_IDX) |-> scaled_o == '0)
    else $error("clamped low, flat or bad index result is not zero");

  // Scaled value never exceeds one
  a_scaled_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> scaled_o <= ScaledOne)
    else $error("scaled result above one");

  // Never push into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !q_push)
    else $error("work queue overflow");

endmodule

// ===== design/mmn_ram.sv =====
// ----------------------------------------------------------------------------
// mmn_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mmn_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/mmn_front.sv =====
// ----------------------------------------------------------------------------
// mmn_front: item intake and classification
// Holds the column count register and the fitted flags, handles clear items
// on its own and queues apply work and in-range fit work for the back end.
// ----------------------------------------------------------------------------
module mmn_front import mmn_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          mode_i,
  input  logic [IdxW-1:0]     feature_index_i,
  input  logic [SampleW-1:0]  sample_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output work_t               q_data_o
);

  logic [CfgW-1:0]      features_q;
  logic [SlotCount-1:0] flags_q, flags_d;
  logic                 accept;
  logic                 col_ok;
  logic                 fitted;
  logic                 is_fit;
  logic                 is_apply;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign col_ok     = {1'b0, feature_index_i} < features_q;
  assign fitted     = flags_q[feature_index_i];
  assign is_fit     = (mode_i == MODE_FIT);
  assign is_apply   = (mode_i == MODE_APPLY);

  // Classify the item and build the work descriptor
  always_comb begin
    q_push_o            = accept && ((is_fit && col_ok) || is_apply);
    q_data_o.op         = is_apply ? OP_APPLY : OP_FIT;
    q_data_o.first      = !fitted;
    q_data_o.preset     = !col_ok || !fitted;
    q_data_o.pre_status = col_ok ? ST_FLAT : ST_BAD_IDX;
    q_data_o.idx        = feature_index_i;
    q_data_o.sample     = sample_i;
  end

  // Drop all flags on clear, mark a column on a valid fit
  always_comb begin
    flags_d = flags_q;
    if (accept && mode_i == MODE_CLEAR) begin
      flags_d = '0;
    end else if (accept && is_fit && col_ok) begin
      flags_d[feature_index_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      features_q <= CfgW'(SlotCount);
      flags_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        features_q <= cfg_wdata_i;
      end
      flags_q <= flags_d;
    end
  end

endmodule

// ===== design/mmn_queue.sv =====
// ----------------------------------------------------------------------------
// mmn_queue: short work queue between front and back end
// A two-entry register FIFO of work descriptors.
// ----------------------------------------------------------------------------
module mmn_queue import mmn_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  work_t data_i,
  input  logic  pop_i,
  output work_t data_o,
  output logic  full_o,
  output logic  empty_o
);

  work_t             entry_q [QueueDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  count_q;

  assign full_o  = (count_q == QCntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign data_o  = entry_q[rd_ptr_q];

  // Store pushed work
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== design/mmn_back.sv =====
// ----------------------------------------------------------------------------
// mmn_back: bounds table, fit update and scaling divider
// Takes work from the queue, reads the column bounds from RAM, folds fit
// samples into them, and runs in-range apply items through a restoring
// divider; every apply result goes into the output register.
// ----------------------------------------------------------------------------
module mmn_back import mmn_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  work_t               q_data_i,
  input  logic                q_empty_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [ScaledW-1:0]  scaled_o,
  output logic [2:0]          status_o
);

  back_state_e          state_q, state_d;
  work_t                cur_q, cur_d;
  logic [RemW-1:0]      rem_q, rem_d;
  logic [RemW-1:0]      den_q, den_d;
  logic [ScaledW-1:0]   quo_q, quo_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [ScaledW-1:0]   res_scaled_q, res_scaled_d;
  status_e              res_status_q, res_status_d;
  logic                 out_valid_q, out_valid_d;
  logic [ScaledW-1:0]   scaled_q, scaled_d;
  status_e              status_q, status_d;

  logic                 ram_we;
  logic [RowW-1:0]      ram_wdata;
  logic [RowW-1:0]      ram_rdata;
  logic signed [SampleW-1:0] lo, hi, smp;
  logic [RemW-1:0]      trial;
  logic                 ge;
  logic [RemW-1:0]      rest;

  // Bounds table: upper half is the maximum, lower half the minimum
  mmn_ram #(
    .Width (RowW),
    .Depth (SlotCount)
  ) u_bounds (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cur_q.idx),
    .wdata_i (ram_wdata),
    .re_i    (q_pop_o),
    .raddr_i (q_data_i.idx),
    .rdata_o (ram_rdata)
  );

  assign lo  = ram_rdata[SampleW-1:0];
  assign hi  = ram_rdata[RowW-1:SampleW];
  assign smp = cur_q.sample;

  // One restoring division step
  assign trial = rem_q;
  assign ge    = (trial >= den_q);
  assign rest  = ge ? (trial - den_q) : trial;

  // Sequencer for fit and apply work
  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    rem_d        = rem_q;
    den_d        = den_q;
    quo_d        = quo_q;
    cnt_d        = cnt_q;
    res_scaled_d = res_scaled_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    scaled_d     = scaled_q;
    status_d     = status_q;
    q_pop_o      = 1'b0;
    ram_we       = 1'b0;
    ram_wdata    = {cur_q.sample, cur_q.sample};

    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_data_i;
          state_d = BK_LOOK;
        end
      end

      BK_LOOK: begin
        if (cur_q.op == OP_FIT) begin
          // Fold the sample into the bounds
          ram_we = 1'b1;
          if (!cur_q.first) begin
            ram_wdata[SampleW-1:0]    = (smp < lo) ? smp : lo;
            ram_wdata[RowW-1:SampleW] = (smp > hi) ? smp : hi;
          end
          state_d = BK_IDLE;
        end else begin
          res_scaled_d = '0;
          res_status_d = ST_OK;
          state_d      = BK_EMIT;
          if (cur_q.preset) begin
            res_status_d = cur_q.pre_status;
          end else if (hi <= lo) begin
            res_status_d = ST_FLAT;
          end else if (smp < lo) begin
            res_status_d = ST_CLAMP_LOW;
          end else if (smp > hi) begin
            res_scaled_d = ScaledOne;
            res_status_d = ST_CLAMP_HIGH;
          end else begin
            // Load numerator and range into the divider
            rem_d   = {smp[SampleW-1], smp} - {lo[SampleW-1], lo};
            den_d   = {hi[SampleW-1], hi} - {lo[SampleW-1], lo};
            quo_d   = '0;
            cnt_d   = '0;
            state_d = BK_DIV;
          end
        end
      end

      BK_DIV: begin
        quo_d = {quo_q[ScaledW-2:0], ge};
        rem_d = {rest[RemW-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(ScaledW - 1)) begin
          res_scaled_d = {quo_q[ScaledW-2:0], ge};
          state_d      = BK_EMIT;
        end
      end

      BK_EMIT: begin
        // Hand the result to the output register once it is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          scaled_d    = res_scaled_q;
          status_d    = res_status_q;
          state_d     = BK_IDLE;
        end
      end

      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    rem_q        <= rem_d;
    den_q        <= den_d;
    quo_q        <= quo_d;
    cnt_q        <= cnt_d;
    res_scaled_q <= res_scaled_d;
    res_status_q <= res_status_d;
    scaled_q     <= scaled_d;
    status_q     <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign scaled_o    = scaled_q;
  assign status_o    = status_q;

endmodule

// ===== bench/normalizer_checker.sv =====
// ----------------------------------------------------------------------------
// normalizer_checker: result predictor and comparator for the normalizer
// Watches the config port and both item channels of the min-max feature
// normalizer, keeps its own per-column bounds, fitted flags and column count,
// predicts the result of every accepted apply item, and compares each
// delivered result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module normalizer_checker import mmn_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [1:0]         mode_i,
  input  logic [IdxW-1:0]    feature_index_i,
  input  logic [SampleW-1:0] sample_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [ScaledW-1:0] scaled_i,
  input  logic [2:0]         status_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [ScaledW-1:0] scaled;
    status_e            status;
  } norm_result_t;

  norm_result_t           expected_results[$];
  longint                 col_min [SlotCount];
  longint                 col_max [SlotCount];
  logic [SlotCount-1:0]   col_fitted;
  logic [CfgW-1:0]        cols_in_use;
  int                     mismatches = 0;

  assign fail_count_o = mismatches;

  // Fold one accepted item into the bounds table; queue a result for apply
  function automatic void track_item(logic [1:0] mode, logic [IdxW-1:0] col,
                                     logic [SampleW-1:0] raw);
    longint            s;
    longint unsigned   rem;
    longint unsigned   den;
    longint unsigned   quo;
    int                limit;
    logic              col_ok;
    norm_result_t      res;
    s      = longint'($signed(raw));
    limit  = (cols_in_use > SlotCount) ? SlotCount : int'(cols_in_use);
    col_ok = int'(col) < limit;
    res.scaled = '0;
    res.status = ST_OK;
    case (mode)
      MODE_CLEAR: col_fitted = '0;
      MODE_FIT: begin
        if (col_ok) begin
          if (!col_fitted[col]) begin
            col_min[col]    = s;
            col_max[col]    = s;
            col_fitted[col] = 1'b1;
          end else begin
            if (s < col_min[col]) col_min[col] = s;
            if (s > col_max[col]) col_max[col] = s;
          end
        end
      end
      MODE_APPLY: begin
        if (!col_ok) begin
          res.status = ST_BAD_IDX;
        end else if (!col_fitted[col] || col_max[col] <= col_min[col]) begin
          res.status = ST_FLAT;
        end else if (s < col_min[col]) begin
          res.status = ST_CLAMP_LOW;
        end else if (s > col_max[col]) begin
          res.scaled = ScaledOne;
          res.status = ST_CLAMP_HIGH;
        end else begin
          // restoring division, truncated: integer bit then FracW fraction bits
          rem = s - col_min[col];
          den = col_max[col] - col_min[col];
          quo = 0;
          if (rem >= den) begin
            rem = rem - den;
            quo = 1;
          end
          for (int i = 0; i < FracW; i++) begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= den) begin
              rem = rem - den;
              quo = quo | 1;
            end
          end
          res.scaled = quo[ScaledW-1:0];
        end
        expected_results.push_back(res);
      end
      default: ;  // unused mode: dropped by the block
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    norm_result_t want;
    if (!rst_ni) begin
      col_fitted  = '0;
      cols_in_use = CfgW'(SlotCount);
      expected_results.delete();
      pending_o <= 0;
    end else begin
      // compare a delivered result first, so an item taken this edge is not matched
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: scaled %0d status %0d",
                 scaled_i, status_i);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (scaled_i !== want.scaled) begin
            $error("scaled mismatch: expected %0d, actual %0d", want.scaled, scaled_i);
            mismatches++;
          end
          if (status_i !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, status_i);
            mismatches++;
          end
        end
      end
      if (cfg_we_i) cols_in_use = cfg_wdata_i;
      if (in_valid_i && in_ready_i) track_item(mode_i, feature_index_i, sample_i);
      pending_o <= expected_results.size();
    end
  end

endmodule

// ===== bench/tb_min_max_feature_normalizer.sv =====
// ----------------------------------------------------------------------------
// tb_min_max_feature_normalizer: top of the normalizer bench
// Drives a directed set of clear, fit, apply and unused-mode items, then
// random phases of fit/apply sequences and noise under several column counts,
// with random idling on both channels and one long output hold-off. The
// checker beside the block predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_min_max_feature_normalizer;
  import mmn_pkg::*;

  localparam int         DrainCycles = 40;
  localparam int         HoldCycles  = 400;
  localparam int         HoldAfter   = 400;
  localparam int         PhaseItems  = 320;
  localparam logic [1:0] ModeUnused  = 2'd3;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgW-1:0]    cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         mode_i;
  logic [IdxW-1:0]    feature_index_i;
  logic [SampleW-1:0] sample_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [ScaledW-1:0] scaled_o;
  logic [2:0]         status_o;

  int          fail_count;
  int          pending;
  int          sent_count = 0;
  int          ignored_count = 0;
  int          columns = SlotCount;
  logic        calm;

  // no idling on either side for a stretch in the middle of the run
  assign calm = (sent_count >= 1200) && (sent_count < 1500);

  min_max_feature_normalizer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .feature_index_i (feature_index_i),
    .sample_i        (sample_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .scaled_o        (scaled_o),
    .status_o        (status_o)
  );

  normalizer_checker result_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .mode_i          (mode_i),
    .feature_index_i (feature_index_i),
    .sample_i        (sample_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .scaled_i        (scaled_o),
    .status_i        (status_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Offer one item, with a random gap first; return at the edge that takes it
  task automatic offer(input logic [1:0] mode, input logic [IdxW-1:0] col,
                       input logic [SampleW-1:0] sample);
    if (!calm && $urandom_range(99) < 36) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (!calm && $urandom_range(99) < 36);
    end
    in_valid_i      <= 1'b1;
    mode_i          <= mode;
    feature_index_i <= col;
    sample_i        <= sample;
    do @(posedge clk_i); while (!in_ready_o);
    sent_count++;
    if (mode == ModeUnused) ignored_count++;
  endtask

  // Hold the input until every result is in and trailing fit items are done
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do begin
      while (pending != 0) @(posedge clk_i);
      repeat (DrainCycles) @(posedge clk_i);
    end while (pending != 0);
  endtask

  task automatic set_columns(input logic [CfgW-1:0] count);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= count;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    columns = int'(count);
  endtask

  // Mostly fit-then-apply sequences on one column, the rest random noise
  task automatic run_phase(input int target);
    int         stop_at;
    int         limit;
    int         col;
    int         spread;
    int         center;
    int         s;
    int         lo;
    int         hi;
    int         n;
    logic [1:0] mode;
    stop_at = sent_count - ignored_count + target;
    limit   = (columns > SlotCount) ? SlotCount : columns;
    while (sent_count - ignored_count < stop_at) begin
      if ($urandom_range(99) < 80) begin
        if (limit > 0 && $urandom_range(99) < 85) col = $urandom_range(limit - 1);
        else col = $urandom_range(SlotCount - 1);
        if ($urandom_range(15) == 0) offer(MODE_CLEAR, IdxW'($urandom), $urandom);
        case ($urandom_range(2))
          0:       spread = $urandom_range(255);
          1:       spread = $urandom_range(1 << 20);
          default: spread = $urandom_range(32'h7fff_ffff);
        endcase
        center = $urandom;
        n = $urandom_range(4, 1);
        for (int k = 0; k < n; k++) begin
          s = center + ($urandom_range(1) ? spread : -spread) / int'($urandom_range(4, 1));
          if (k == 0 || s < lo) lo = (k == 0) ? s : s;
          if (k == 0) hi = s;
          else if (s > hi) hi = s;
          offer(MODE_FIT, IdxW'(col), s);
        end
        n = $urandom_range(4, 1);
        for (int k = 0; k < n; k++) begin
          case ($urandom_range(5))
            0:       s = lo;
            1:       s = hi;
            2:       s = center + ($urandom_range(1) ? spread : -spread)
                         / int'($urandom_range(8, 1));
            3:       s = lo - int'($urandom_range(256, 1));
            4:       s = hi + int'($urandom_range(256, 1));
            default: s = $urandom;
          endcase
          offer(MODE_APPLY, IdxW'(col), s);
        end
      end else begin
        mode = 2'($urandom_range(3));
        if (mode == MODE_CLEAR && $urandom_range(3) != 0) mode = MODE_APPLY;
        offer(mode, IdxW'($urandom_range(SlotCount - 1)), $urandom);
      end
    end
  endtask

  // Stimulus
  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    mode_i          = MODE_CLEAR;
    feature_index_i = '0;
    sample_i        = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_columns(7'd64);

    // extremes, clamping, flat ranges, unused mode, clear and refit
    offer(MODE_CLEAR, 6'd0,  32'h0000_0000);
    offer(MODE_APPLY, 6'd5,  32'h0000_0000);
    offer(MODE_FIT,   6'd0,  32'h8000_0000);
    offer(MODE_APPLY, 6'd0,  32'h8000_0000);
    offer(MODE_FIT,   6'd0,  32'h7fff_ffff);
    offer(MODE_APPLY, 6'd0,  32'h8000_0000);
    offer(MODE_APPLY, 6'd0,  32'h7fff_ffff);
    offer(MODE_APPLY, 6'd0,  32'h0000_0000);
    offer(MODE_FIT,   6'd63, 32'h0001_0000);
    offer(MODE_FIT,   6'd63, 32'h0003_0000);
    offer(MODE_APPLY, 6'd63, 32'h0000_0000);
    offer(MODE_APPLY, 6'd63, 32'h0004_0000);
    offer(MODE_APPLY, 6'd63, 32'h0002_0000);
    offer(MODE_APPLY, 6'd63, 32'h0001_5555);
    offer(ModeUnused, 6'd63, 32'hffff_ffff);
    offer(MODE_FIT,   6'd63, 32'h0002_0000);
    offer(MODE_APPLY, 6'd63, 32'h0003_0000);
    offer(MODE_CLEAR, 6'd63, 32'hffff_ffff);
    offer(MODE_APPLY, 6'd63, 32'h0002_0000);
    offer(MODE_FIT,   6'd63, 32'hffff_0000);
    offer(MODE_APPLY, 6'd63, 32'hffff_0000);
    set_columns(7'd1);
    offer(MODE_FIT,   6'd1,  32'h0005_0000);
    offer(MODE_APPLY, 6'd1,  32'h0005_0000);
    offer(MODE_APPLY, 6'd0,  32'h0005_0000);
    set_columns(7'd0);
    offer(MODE_FIT,   6'd0,  32'h0001_0000);
    offer(MODE_APPLY, 6'd0,  32'h0001_0000);

    // random phases over several column counts
    set_columns(7'd64);
    run_phase(PhaseItems);
    set_columns(CfgW'($urandom_range(64, 1)));
    run_phase(PhaseItems);
    set_columns(7'd1);
    run_phase(PhaseItems);
    set_columns(7'd127);
    run_phase(PhaseItems);
    set_columns(7'd0);
    run_phase(PhaseItems / 4);
    set_columns(CfgW'($urandom_range(63, 2)));
    run_phase(PhaseItems);
    set_columns(7'd64);
    run_phase(PhaseItems);

    wait_idle();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Output side: random stalls, one long hold-off while the sender keeps going
  initial begin
    bit held;
    held        = 1'b0;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (!held && sent_count >= HoldAfter) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      out_ready_i <= calm || ($urandom_range(99) >= 36);
    end
  end

  // Guard against a hung run
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
design/mmn_pkg.sv
design/mmn_ram.sv
design/mmn_front.sv
design/mmn_queue.sv
design/mmn_back.sv
design/min_max_feature_normalizer.sv
bench/normalizer_checker.sv
bench/tb_min_max_feature_normalizer.sv
